### rtl/qra_pkg.sv
// ----------------------------------------------------------------------------
// qra_pkg
// Shared types and constants of the quadtree rectangle allocator.
// ----------------------------------------------------------------------------
package qra_pkg;

    localparam int PAGE_LOG_DEF = 6;
    localparam int PAGES_DEF    = 4;

    localparam int CFG_W = 3;
    localparam logic [CFG_W-1:0] CFG_PAGES_RESET = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_RESET = 1'b1;

    localparam int REQ_W   = 7;
    localparam int COUNT_W = 15;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 15'd32767;

    // Node status codes
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_USED  = 2'd1;
    localparam logic [1:0] ST_SPLIT = 2'd2;

    // Child slot offsets in halves: bit 1 is x, bit 0 is y.
    // Slots are visited from 3 down to 0.
    typedef logic [1:0] quad_off_t;
    localparam quad_off_t QUAD_OFF [0:3] = '{2'b10, 2'b11, 2'b01, 2'b00};

    typedef struct packed {
        logic        found;
        logic [1:0]  page;
        logic [5:0]  origin_x;
        logic [5:0]  origin_y;
        logic [6:0]  cell_size;
        logic [13:0] alloc_index;
    } res_t;

endpackage

### rtl/quadtree_rectangle_allocator.sv
// ----------------------------------------------------------------------------
// quadtree_rectangle_allocator
// Square-cell allocator over several power-of-two atlas pages, each kept as
// a quadtree whose node status lives in one synchronous memory.
// ----------------------------------------------------------------------------
// Walk: a node read passes the address, then the evaluate state; a node
//   skipped as too small passes the address, then the advance state, which
//   also makes each sibling, climb or page step; the output register follows.
// Throughput: one transaction at a time; the walk through the memory port
//   sets the rate, bounded by the node count of the searched pages.
// Reset: aresetn and every reset request run a clearing sweep over all
//   PAGES*(4^(PAGE_LOG+1)-1)/3 nodes (21844 by default) with s_ready low.
module quadtree_rectangle_allocator
    import qra_pkg::*;
#(
    parameter int PAGE_LOG = PAGE_LOG_DEF,
    parameter int PAGES    = PAGES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_opcode,
    input  logic [REQ_W-1:0] s_req_width,
    input  logic [REQ_W-1:0] s_req_height,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_found,
    output logic [1:0]       m_page,
    output logic [5:0]       m_origin_x,
    output logic [5:0]       m_origin_y,
    output logic [6:0]       m_cell_size,
    output logic [13:0]      m_alloc_index
);

    logic [CFG_W-1:0] pages_reg;
    logic             m_valid_reg;
    res_t             out_reg;
    logic             res_valid;
    logic             res_ready;
    res_t             res;

    // Page count register, to be written only while idle; the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pages_reg <= CFG_PAGES_RESET;
        end else if (cfg_wr_en) begin
            pages_reg <= cfg_wr_data;
        end
    end

    // The walker hands a result over once the output stage is free
    assign res_ready = !m_valid_reg || m_ready;

    qra_search #(.PAGE_LOG(PAGE_LOG), .PAGES(PAGES)) u_search (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pages_in_use (pages_reg),
        .req_valid    (s_valid),
        .req_ready    (s_ready),
        .req_opcode   (s_opcode),
        .req_width    (s_req_width),
        .req_height   (s_req_height),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // Output register: hold the result until the transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = out_reg.found;
    assign m_page        = out_reg.page;
    assign m_origin_x    = out_reg.origin_x;
    assign m_origin_y    = out_reg.origin_y;
    assign m_cell_size   = out_reg.cell_size;
    assign m_alloc_index = out_reg.alloc_index;

endmodule

### rtl/qra_node_mem.sv
// ----------------------------------------------------------------------------
// qra_node_mem
// Single-port node status memory, registered read.
// ----------------------------------------------------------------------------
module qra_node_mem
    import qra_pkg::*;
#(
    parameter int DEPTH = 21844,
    parameter int AW    = 15
) (
    input  logic          aclk,
    input  logic [AW-1:0] addr,
    input  logic          we,
    input  logic [1:0]    wdata,
    output logic [1:0]    rdata
);

    logic [1:0] mem [0:DEPTH-1];
    logic [1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/qra_search.sv
// ----------------------------------------------------------------------------
// qra_search
// Depth-first quadtree walker: reads, splits and marks nodes in the status
// memory, and runs the clearing sweep.
// ----------------------------------------------------------------------------
module qra_search
    import qra_pkg::*;
#(
    parameter int PAGE_LOG = PAGE_LOG_DEF,
    parameter int PAGES    = PAGES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CFG_W-1:0] pages_in_use,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic             req_opcode,
    input  logic [REQ_W-1:0] req_width,
    input  logic [REQ_W-1:0] req_height,
    output logic             res_valid,
    input  logic             res_ready,
    output res_t             res
);

    localparam int NPP   = ((1 << (2 * (PAGE_LOG + 1))) - 1) / 3;
    localparam int TOTAL = PAGES * NPP;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int NW    = (NPP > 1) ? $clog2(NPP) : 1;
    localparam int DW    = $clog2(PAGE_LOG + 1);
    localparam int SW    = PAGE_LOG + 1;
    localparam int CW    = (SW > REQ_W) ? SW : REQ_W;
    localparam int NPW   = $clog2(PAGES + 1);
    localparam int CAPW  = (NPW > CFG_W) ? NPW : CFG_W;
    localparam logic [SW-1:0] SIDE = SW'(1) << PAGE_LOG;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_VISIT = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_ADV   = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]         state_reg,   state_next;
    logic [AW-1:0]      clr_reg,     clr_next;
    logic               pend_reg,    pend_next;
    logic [NPW-1:0]     page_reg,    page_next;
    logic [NPW-1:0]     npg_reg,     npg_next;
    logic [AW-1:0]      base_reg,    base_next;
    logic [NW-1:0]      node_reg,    node_next;
    logic [DW-1:0]      depth_reg,   depth_next;
    logic [PAGE_LOG-1:0] x_reg,      x_next;
    logic [PAGE_LOG-1:0] y_reg,      y_next;
    logic [REQ_W-1:0]   w_reg,       w_next;
    logic [REQ_W-1:0]   h_reg,       h_next;
    logic [COUNT_W-1:0] count_reg,   count_next;
    res_t               res_reg,     res_next;

    logic [AW-1:0]       mem_addr;
    logic                mem_we;
    logic [1:0]          mem_wdata;
    logic [1:0]          mem_rdata;
    logic [SW-1:0]       side;
    logic [PAGE_LOG-1:0] side_low;
    logic [PAGE_LOG-1:0] px, py;
    logic [NW-1:0]       node_m1;
    logic [1:0]          slot;
    logic [1:0]          off;
    logic                fits, oversized, last_level;
    logic [CAPW-1:0]     cfg_cap;

    assign side       = SIDE >> depth_reg;
    assign side_low   = side[PAGE_LOG-1:0];
    assign fits       = (CW'(w_reg) <= CW'(side)) && (CW'(h_reg) <= CW'(side));
    assign oversized  = ({1'b0, CW'(w_reg)} << 1) <= {1'b0, CW'(side)} &&
                        ({1'b0, CW'(h_reg)} << 1) <= {1'b0, CW'(side)};
    assign last_level = (depth_reg == DW'(PAGE_LOG));
    assign px         = x_reg & ~side_low;
    assign py         = y_reg & ~side_low;
    assign node_m1    = node_reg - NW'(1);
    assign slot       = node_m1[1:0];
    assign off        = QUAD_OFF[slot - 2'd1];
    assign cfg_cap    = (CAPW'(pages_in_use) > CAPW'(PAGES)) ? CAPW'(PAGES)
                                                             : CAPW'(pages_in_use);

    assign mem_addr  = (state_reg == S_CLEAR) ? clr_reg : (base_reg + AW'(node_reg));
    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;

    qra_node_mem #(.DEPTH(TOTAL), .AW(AW)) u_mem (
        .aclk  (aclk),
        .addr  (mem_addr),
        .we    (mem_we),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        pend_next  = pend_reg;
        page_next  = page_reg;
        npg_next   = npg_reg;
        base_next  = base_reg;
        node_next  = node_reg;
        depth_next = depth_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        count_next = count_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_wdata  = ST_FREE;

        unique case (state_reg)
            S_CLEAR: begin
                mem_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(TOTAL - 1)) begin
                    res_next   = '0;
                    state_next = pend_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_valid) begin
                    w_next    = req_width;
                    h_next    = req_height;
                    res_next  = '0;
                    page_next = '0;
                    base_next = '0;
                    node_next = '0;
                    depth_next = '0;
                    x_next    = '0;
                    y_next    = '0;
                    npg_next  = NPW'(cfg_cap);
                    if (req_opcode == OP_RESET) begin
                        count_next = '0;
                        clr_next   = '0;
                        pend_next  = 1'b1;
                        state_next = S_CLEAR;
                    end else if (req_width == '0 || req_height == '0 ||
                                 cfg_cap == '0) begin
                        state_next = S_RESP;
                    end else begin
                        state_next = S_VISIT;
                    end
                end
            end
            S_VISIT: begin
                // skip a subtree too small for the request, else read the node
                state_next = fits ? S_EVAL : S_ADV;
            end
            S_EVAL: begin
                priority if (mem_rdata == ST_FREE && !oversized) begin
                    mem_we    = 1'b1;
                    mem_wdata = ST_USED;
                    res_next.found       = 1'b1;
                    res_next.page        = 2'(page_reg);
                    res_next.origin_x    = 6'(x_reg);
                    res_next.origin_y    = 6'(y_reg);
                    res_next.cell_size   = 7'(side);
                    res_next.alloc_index = count_reg[13:0];
                    if (count_reg != COUNT_MAX) begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    state_next = S_RESP;
                end else if ((mem_rdata == ST_FREE || mem_rdata == ST_SPLIT) &&
                             !last_level) begin
                    // children of a free leaf are already free since the last sweep
                    if (mem_rdata == ST_FREE) begin
                        mem_we    = 1'b1;
                        mem_wdata = ST_SPLIT;
                    end
                    node_next  = {node_reg[NW-3:0], 2'b00} + NW'(4);
                    depth_next = depth_reg + DW'(1);
                    state_next = S_VISIT;
                end else begin
                    state_next = S_ADV;
                end
            end
            S_ADV: begin
                if (depth_reg == '0) begin
                    if (page_reg + NPW'(1) < npg_reg) begin
                        page_next  = page_reg + NPW'(1);
                        base_next  = base_reg + AW'(NPP);
                        node_next  = '0;
                        x_next     = '0;
                        y_next     = '0;
                        state_next = S_VISIT;
                    end else begin
                        res_next   = '0;
                        state_next = S_RESP;
                    end
                end else if (slot != 2'd0) begin
                    node_next  = node_m1;
                    x_next     = px | (off[1] ? side_low : '0);
                    y_next     = py | (off[0] ? side_low : '0);
                    state_next = S_VISIT;
                end else begin
                    // all children tried: climb and keep advancing
                    node_next  = node_m1 >> 2;
                    depth_next = depth_reg - DW'(1);
                    x_next     = px;
                    y_next     = py;
                end
            end
            S_RESP: begin
                if (res_ready) begin
                    pend_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
        end
        page_reg  <= page_next;
        npg_reg   <= npg_next;
        base_reg  <= base_next;
        node_reg  <= node_next;
        depth_reg <= depth_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        w_reg     <= w_next;
        h_reg     <= h_next;
        res_reg   <= res_next;
    end

endmodule

### rtl/qra_checker.sv
// ----------------------------------------------------------------------------
// qra_checker
// Port-level assertions for the quadtree rectangle allocator.
// ----------------------------------------------------------------------------
module qra_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_found,
    input logic [1:0]  m_page,
    input logic [5:0]  m_origin_x,
    input logic [5:0]  m_origin_y,
    input logic [6:0]  m_cell_size,
    input logic [13:0] m_alloc_index
);

    // A stalled result stays valid and keeps its found flag, origin and cell size
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) &&
        $stable(m_origin_x) && $stable(m_origin_y) && $stable(m_cell_size))
        else $error("result changed while stalled");

    // A miss carries all-zero fields
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_page == 2'd0 && m_origin_x == 6'd0 &&
        m_origin_y == 6'd0 && m_cell_size == 7'd0 && m_alloc_index == 14'd0)
        else $error("miss with nonzero fields");

    // An allocated cell is a power-of-two square
    a_cell_pow2: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> $onehot(m_cell_size))
        else $error("cell size not a power of two");

    // One request in flight at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

endmodule

bind quadtree_rectangle_allocator qra_checker u_qra_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_found       (m_found),
    .m_page        (m_page),
    .m_origin_x    (m_origin_x),
    .m_origin_y    (m_origin_y),
    .m_cell_size   (m_cell_size),
    .m_alloc_index (m_alloc_index)
);
